FILE: sv/bcld_pkg.sv
`default_nettype none
package bcld_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int TOUCH_W    = 16;
	localparam int ID_W       = 32;
	localparam int SLOT_W     = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int ENTRY_W    = ID_W + TOUCH_W;

	localparam int BS_W       = 17;
	localparam int CAP_W      = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;
	localparam int OFF_W      = 22;
	localparam int OUT_SLOT_W = 6;
	localparam int ACT_W      = 2;
	localparam int STATUS_W   = 3;
	localparam int MIN_CAP    = 2;

	localparam int BS_RESET   = 4096;
	localparam int CAP_RESET  = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_ALLOC  = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_HIT     = 3'd0,
		STS_MISS    = 3'd1,
		STS_NEW     = 3'd2,
		STS_EVICT   = 3'd3,
		STS_DUP     = 3'd4,
		STS_CLEARED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic decide;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic last_addr;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

FILE: sv/bcld_ram.sv
`default_nettype none
module bcld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/bcld_ctrl.sv
`default_nettype none
module bcld_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire bcld_pkg::stat_t stat,
	output bcld_pkg::cmd_t      cmd
);
	import bcld_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.need_scan ? ST_SCAN : ST_DECIDE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.last_addr) begin
					state_d = ST_DRAIN;
				end
			end
			// last read word is compared here
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/bcld_dpath.sv
`default_nettype none
module bcld_dpath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [bcld_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bcld_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [bcld_pkg::ACT_W-1:0]     in_action,
	input  wire logic [bcld_pkg::ID_W-1:0]      in_id,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic [bcld_pkg::STATUS_W-1:0]       out_status,
	output logic [bcld_pkg::OUT_SLOT_W-1:0]     out_slot,
	output logic [bcld_pkg::ID_W-1:0]           out_evicted,
	output logic [bcld_pkg::OFF_W-1:0]          out_offset,
	input  wire bcld_pkg::cmd_t                 cmd,
	output bcld_pkg::stat_t                     stat
);
	import bcld_pkg::*;

	localparam int PROD_W = SLOT_W + BS_W;
	localparam logic [TOUCH_W-1:0] TOUCH_MAX = '1;

	// configuration
	logic [BS_W-1:0]  block_size_q;
	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] cap_eff;

	// directory control
	logic [CNT_W-1:0]  used_q, used_d;
	logic [SLOT_W-1:0] rd_ptr_q;
	action_t           act_q;
	logic [ID_W-1:0]   id_q;

	// scan compare stage
	logic              cmp_vld_s1;
	logic [SLOT_W-1:0] cmp_idx_s1;
	logic [ENTRY_W-1:0] rdata;
	logic [ID_W-1:0]    rd_id;
	logic [TOUCH_W-1:0] rd_touch;

	logic               found_q;
	logic [SLOT_W-1:0]  match_slot_q;
	logic [TOUCH_W-1:0] match_touch_q;
	logic [SLOT_W-1:0]  best_slot_q;
	logic [TOUCH_W-1:0] best_touch_q;
	logic [ID_W-1:0]    best_id_q;

	// decision
	logic               we;
	logic [SLOT_W-1:0]  waddr;
	logic [TOUCH_W-1:0] wtouch;
	status_t            res_status_d, res_status_q;
	logic [SLOT_W-1:0]  res_slot_d, res_slot_q;
	logic [ID_W-1:0]    res_ev_d, res_ev_q;
	logic               res_off_d, res_off_q;
	logic [PROD_W-1:0]  prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BS_W'(BS_RESET);
			capacity_q   <= CAP_W'(CAP_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BLOCK_SIZE: block_size_q <= cfg_data[BS_W-1:0];
				CFG_CAPACITY:   capacity_q   <= cfg_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (CNT_W'(capacity_q) < CNT_W'(MIN_CAP)) begin
			cap_eff = CNT_W'(MIN_CAP);
		end else if (CNT_W'(capacity_q) > CNT_W'(MAX_BLOCKS)) begin
			cap_eff = CNT_W'(MAX_BLOCKS);
		end else begin
			cap_eff = CNT_W'(capacity_q);
		end
	end

	assign stat.need_scan = (in_action == ACT_LOOKUP || in_action == ACT_ALLOC)
		&& (used_q != '0);
	assign stat.last_addr = ({1'b0, rd_ptr_q} == used_q - CNT_W'(1));
	assign stat.out_free  = !out_valid || out_ready;

	bcld_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_BLOCKS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata({id_q, wtouch}),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	assign rd_id    = rdata[ENTRY_W-1:TOUCH_W];
	assign rd_touch = rdata[TOUCH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan;
			if (cmd.decide) begin
				used_q <= used_d;
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_ptr_q;
		if (cmd.load) begin
			rd_ptr_q <= '0;
			found_q  <= 1'b0;
			act_q    <= action_t'(in_action);
			id_q     <= in_id;
		end else if (cmd.scan) begin
			rd_ptr_q <= rd_ptr_q + SLOT_W'(1);
		end
		if (cmp_vld_s1) begin
			// first match wins
			if (!found_q && rd_id == id_q) begin
				found_q       <= 1'b1;
				match_slot_q  <= cmp_idx_s1;
				match_touch_q <= rd_touch;
			end
			// eviction candidate, slot 0 excluded, lowest slot on ties
			if (cmp_idx_s1 == SLOT_W'(1) ||
			    (cmp_idx_s1 > SLOT_W'(1) && rd_touch < best_touch_q)) begin
				best_slot_q  <= cmp_idx_s1;
				best_touch_q <= rd_touch;
				best_id_q    <= rd_id;
			end
		end
		if (cmd.decide) begin
			res_status_q <= res_status_d;
			res_slot_q   <= res_slot_d;
			res_ev_q     <= res_ev_d;
			res_off_q    <= res_off_d;
		end
	end

	always_comb begin
		we           = 1'b0;
		waddr        = match_slot_q;
		wtouch       = (match_touch_q == TOUCH_MAX) ? match_touch_q
			: match_touch_q + TOUCH_W'(1);
		used_d       = used_q;
		res_status_d = STS_MISS;
		res_slot_d   = '0;
		res_ev_d     = '0;
		res_off_d    = 1'b0;
		unique case (act_q)
			ACT_LOOKUP: begin
				if (found_q) begin
					we           = cmd.decide;
					res_status_d = STS_HIT;
					res_slot_d   = match_slot_q;
					res_off_d    = 1'b1;
				end
			end
			ACT_ALLOC: begin
				res_off_d = 1'b1;
				if (found_q) begin
					we           = cmd.decide;
					res_status_d = STS_DUP;
					res_slot_d   = match_slot_q;
				end else if (used_q < cap_eff) begin
					we           = cmd.decide;
					waddr        = used_q[SLOT_W-1:0];
					wtouch       = '0;
					used_d       = used_q + CNT_W'(1);
					res_status_d = STS_NEW;
					res_slot_d   = used_q[SLOT_W-1:0];
				end else begin
					we           = cmd.decide;
					waddr        = best_slot_q;
					wtouch       = '0;
					res_status_d = STS_EVICT;
					res_slot_d   = best_slot_q;
					res_ev_d     = best_id_q;
				end
			end
			ACT_CLEAR: begin
				used_d       = '0;
				res_status_d = STS_CLEARED;
			end
			default: ;
		endcase
	end

	assign prod = PROD_W'(res_slot_q) * PROD_W'(block_size_q);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status  <= res_status_q;
			out_slot    <= OUT_SLOT_W'(res_slot_q);
			out_evicted <= res_ev_q;
			out_offset  <= res_off_q ? prod[OFF_W-1:0] : '0;
		end
	end

endmodule
`default_nettype wire

FILE: sv/block_cache_lfu_directory_top.sv
`default_nettype none
// lfu slot directory for a block cache. one request beat on the slave side (lookup, allocate
// or clear) gives exactly one result beat on the master side. the slot table (id and touch
// count per slot) sits in a single-port-write, registered-read ram and is scanned one slot
// per cycle through its read port, so a lookup or allocate on a non-empty table passes the
// scan, drain, decide and done states before the next accept, and a clear, an unknown action
// or any request on an empty table goes straight to decide and done; done waits while the output
// register stays full at hand-off. one scan serves both the id match and the
// eviction search (smallest touch count among slots 1 and up, lowest slot on ties). the table
// needs no clearing pass after reset: only slots below the fill count are ever read. a
// finished result waits in the output register while the next request is already accepted.
// configuration must be written only while idle (not enforced); cfg_ready is always high.
module block_cache_lfu_directory_top (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,     // 0 block_size, 1 capacity
	input  wire logic [16:0] cfg_data,

	// request beats
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] block_id
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] action

	// result beats
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // [5:0] slot, [37:6] evicted_id,
	                                        // [59:38] buffer_offset, [63:60] zero
	output logic [2:0]       m_axis_tuser   // [2:0] status
);
	import bcld_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	logic [OUT_SLOT_W-1:0] out_slot;
	logic [ID_W-1:0]       out_evicted;
	logic [OFF_W-1:0]      out_offset;

	assign cfg_ready = 1'b1;

	// sequencer: accept, scan, drain, decide, hand off to output register
	bcld_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// table, scan compare, config registers, offset multiply and output register
	bcld_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_action  (s_axis_tuser),
		.in_id      (s_axis_tdata),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_status (m_axis_tuser),
		.out_slot   (out_slot),
		.out_evicted(out_evicted),
		.out_offset (out_offset),
		.cmd        (cmd),
		.stat       (stat)
	);

	assign m_axis_tdata = {4'b0, out_offset, out_evicted, out_slot};

endmodule
`default_nettype wire
